// File: src/i2cscd_pkg.sv
// ----------------------------------------------------------------------------
// i2cscd_pkg
// Types and codes shared by the I2C slave command/register decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cscd_pkg;

  // slave phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_SEND = 2'd2
  } phase_t;

  // event kinds
  localparam logic [1:0] CMD_ADDR  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // position of a data byte within a write
  localparam logic [1:0] IDX_SELECT = 2'd0;
  localparam logic [1:0] IDX_TARGET = 2'd1;
  localparam logic [1:0] IDX_OP     = 2'd2;

  // read register selects
  localparam logic [7:0] REG_ID       = 8'd1;
  localparam logic [7:0] REG_CONFIG   = 8'd2;
  localparam logic [7:0] REG_IO_STATE = 8'd3;
  localparam logic [7:0] REG_BATTERY  = 8'd4;
  localparam logic [7:0] REG_PANEL    = 8'd5;

  // write targets
  localparam logic [7:0] TGT_BUTTON  = 8'd1;
  localparam logic [7:0] TGT_STATUS  = 8'd2;
  localparam logic [7:0] TGT_WARNING = 8'd3;
  localparam logic [7:0] TGT_CALL    = 8'd4;
  localparam logic [7:0] TGT_GSM     = 8'd5;

  // operation codes
  localparam logic [7:0] OP_0 = 8'd0;
  localparam logic [7:0] OP_1 = 8'd1;
  localparam logic [7:0] OP_2 = 8'd2;
  localparam logic [7:0] OP_3 = 8'd3;

  // led modes
  localparam logic [2:0] MODE_OFF  = 3'd0;
  localparam logic [2:0] MODE_ON   = 3'd1;
  localparam logic [2:0] MODE_HALF = 3'd2;
  localparam logic [2:0] MODE_ONE  = 3'd3;
  localparam logic [2:0] MODE_TWO  = 3'd4;
  localparam logic [2:0] MODE_FOUR = 3'd5;

  localparam logic [7:0] ID_CODE = 8'h16;

  // one input event
  typedef struct packed {
    logic [15:0] solar_level;
    logic [7:0]  battery_level;
    logic [7:0]  gpio_state;
    logic [7:0]  config_value;
    logic        overflow;
    logic        nack;
    logic [7:0]  data_byte;
    logic        read_not_write;
    logic [1:0]  cmd;
  } item_t;

  // one result
  typedef struct packed {
    logic       overflow_cleared;
    logic       gsm_enable;
    logic [7:0] call_request;
    logic [2:0] warning_led_mode;
    logic [2:0] status_led_mode;
    logic [2:0] button_led_mode;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

`default_nettype wire

// File: src/i2cscd_core.sv
// ----------------------------------------------------------------------------
// i2cscd_core
// Slave state registers and the decode of one event into next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cscd_core
  import i2cscd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      result
);

  phase_t     phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] reply0_r, reply0_nxt;
  logic [7:0] reply1_r, reply1_nxt;
  logic [2:0] button_r, button_nxt;
  logic [2:0] status_r, status_nxt;
  logic [2:0] warning_r, warning_nxt;
  logic [7:0] call_r, call_nxt;
  logic       gsm_r, gsm_nxt;
  logic       txv;
  logic [7:0] txb;
  logic       ovc;
  logic       in_recv;
  logic       data_ok;

  assign in_recv = (phase_r == PH_RECV);
  // a data byte that is taken into the write sequence
  assign data_ok = (phase_r != PH_SEND) && in_recv && (item.cmd == CMD_DATA) &&
                   !item.overflow && !item.read_not_write;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r == PH_SEND) begin
      if (item.cmd == CMD_ACK && item.nack) begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      phase_nxt = in_recv ? PH_RECV : PH_IDLE;
      if (item.cmd == CMD_ADDR) begin
        phase_nxt = item.read_not_write ? PH_SEND : PH_RECV;
      end else if (data_ok && idx_r != IDX_SELECT && idx_r != IDX_TARGET) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // byte index, replies, targets and transmit output
  always_comb begin
    idx_nxt     = idx_r;
    target_nxt  = target_r;
    reply0_nxt  = reply0_r;
    reply1_nxt  = reply1_r;
    button_nxt  = button_r;
    status_nxt  = status_r;
    warning_nxt = warning_r;
    call_nxt    = call_r;
    gsm_nxt     = gsm_r;
    txv         = 1'b0;
    txb         = 8'd0;
    ovc         = 1'b0;
    if (phase_r == PH_SEND) begin
      if (item.cmd == CMD_ACK && !item.nack) begin
        txv = 1'b1;
        txb = reply1_r;
      end
    end else if (item.cmd == CMD_ADDR) begin
      idx_nxt = IDX_SELECT;
      if (item.read_not_write) begin
        txv = 1'b1;
        txb = reply0_r;
      end
    end else if (item.cmd == CMD_DATA && in_recv && item.overflow) begin
      ovc = 1'b1;
    end else if (data_ok) begin
      case (idx_r)
        IDX_SELECT: begin
          idx_nxt = IDX_TARGET;
          case (item.data_byte)
            REG_ID: begin
              reply0_nxt = ID_CODE;
              reply1_nxt = 8'd0;
            end
            REG_CONFIG: begin
              reply0_nxt = item.config_value;
              reply1_nxt = 8'd0;
            end
            REG_IO_STATE: begin
              reply0_nxt = item.gpio_state;
              reply1_nxt = 8'd0;
            end
            REG_BATTERY: begin
              reply0_nxt = item.battery_level;
              reply1_nxt = 8'd0;
            end
            REG_PANEL: begin
              reply0_nxt = item.solar_level[7:0];
              reply1_nxt = item.solar_level[15:8];
            end
            default: ;
          endcase
        end
        IDX_TARGET: begin
          target_nxt = item.data_byte;
          idx_nxt    = IDX_OP;
        end
        default: begin
          idx_nxt = IDX_SELECT;
          case (target_r)
            TGT_BUTTON: begin
              case (item.data_byte)
                OP_0:    button_nxt = MODE_ONE;
                OP_1:    button_nxt = MODE_TWO;
                OP_2:    button_nxt = MODE_HALF;
                OP_3:    button_nxt = MODE_ON;
                default: ;
              endcase
            end
            TGT_STATUS: begin
              case (item.data_byte)
                OP_0:    status_nxt = MODE_FOUR;
                OP_1:    status_nxt = MODE_ON;
                OP_2:    status_nxt = MODE_OFF;
                OP_3:    status_nxt = MODE_ONE;
                default: ;
              endcase
            end
            TGT_WARNING: begin
              case (item.data_byte)
                OP_0:    warning_nxt = MODE_TWO;
                OP_1:    warning_nxt = MODE_OFF;
                default: ;
              endcase
            end
            TGT_CALL: call_nxt = item.data_byte;
            TGT_GSM: begin
              case (item.data_byte)
                OP_0: begin
                  gsm_nxt    = 1'b0;
                  button_nxt = MODE_ON;
                end
                OP_1: begin
                  gsm_nxt    = 1'b1;
                  button_nxt = MODE_HALF;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  // state registers, updated once per processed event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      idx_r     <= IDX_SELECT;
      target_r  <= 8'd0;
      reply0_r  <= 8'd0;
      reply1_r  <= 8'd0;
      button_r  <= MODE_OFF;
      status_r  <= MODE_OFF;
      warning_r <= MODE_OFF;
      call_r    <= 8'd0;
      gsm_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      target_r  <= target_nxt;
      reply0_r  <= reply0_nxt;
      reply1_r  <= reply1_nxt;
      button_r  <= button_nxt;
      status_r  <= status_nxt;
      warning_r <= warning_nxt;
      call_r    <= call_nxt;
      gsm_r     <= gsm_nxt;
    end
  end

  // result shows state after the event
  assign result.tx_valid         = txv;
  assign result.tx_byte          = txb;
  assign result.button_led_mode  = button_nxt;
  assign result.status_led_mode  = status_nxt;
  assign result.warning_led_mode = warning_nxt;
  assign result.call_request     = call_nxt;
  assign result.gsm_enable       = gsm_nxt;
  assign result.overflow_cleared = ovc;

endmodule

`default_nettype wire

// File: src/i2c_slave_command_register_decoder.sv
// ----------------------------------------------------------------------------
// i2c_slave_command_register_decoder
// Decodes I2C slave events into register replies and LED/call/GSM controls.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one slave event per transfer: the event kind in
//   in_tuser, the received byte, flags and the live register values in
//   in_tdata. The out_ stream returns exactly one result per event: the
//   byte to transmit (if any) and the current control outputs.
//   An accepted event sits in an input register; it is decoded against the
//   slave state and the result is written to the output register once
//   that register is empty or its held result is taken.
//   One event per cycle is sustained while the receiver does not stall; the
//   single decode pass between the input and output registers sets that figure.
//   When the receiver stalls, the held result stays on out_tdata and the
//   input register still takes one more event; after that in_tready drops
//   until the result is taken.
//   Synchronous reset (rst_n low) empties both registers and returns the
//   slave to idle with all modes off, replies, call request and GSM cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_command_register_decoder
  import i2cscd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [0] read_not_write, [8:1] data_byte, [9] nack, [10] overflow,
  // [18:11] config_value, [26:19] gpio_state, [34:27] battery_level,
  // [50:35] solar_level, [55:51] zero
  input  wire logic [55:0] in_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [0] tx_valid, [8:1] tx_byte, [11:9] button_led_mode,
  // [14:12] status_led_mode, [17:15] warning_led_mode, [25:18] call_request,
  // [26] gsm_enable, [27] overflow_cleared, [31:28] zero
  output      logic [31:0] out_tdata
);

  logic    in_valid_r;
  item_t   in_item_r;
  item_t   item_nxt;
  logic    out_valid_r;
  result_t out_res_r;
  result_t result;
  logic    advance;
  logic    fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // unpack the input transfer
  assign item_nxt.cmd            = in_tuser;
  assign item_nxt.read_not_write = in_tdata[0];
  assign item_nxt.data_byte      = in_tdata[8:1];
  assign item_nxt.nack           = in_tdata[9];
  assign item_nxt.overflow       = in_tdata[10];
  assign item_nxt.config_value   = in_tdata[18:11];
  assign item_nxt.gpio_state     = in_tdata[26:19];
  assign item_nxt.battery_level  = in_tdata[34:27];
  assign item_nxt.solar_level    = in_tdata[50:35];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_nxt;
    end
  end

  i2cscd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};

endmodule

`default_nettype wire
